@@ rtl/threshold_run_peak_finder_assert.svh @@
// Assertion helpers shared by the RTL.
`ifndef THRESHOLD_RUN_PEAK_FINDER_ASSERT_SVH
`define THRESHOLD_RUN_PEAK_FINDER_ASSERT_SVH

// Same-cycle implication, masked while in reset.
`define TRPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while in reset.
`define TRPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/trpf_pkg.sv @@
`default_nettype none
package trpf_pkg;

  // Strip length limit; bins past this are dropped.
  localparam int MAX_BINS = 1024;

  localparam int BIN_W   = $clog2(MAX_BINS);
  localparam int CNT_W   = $clog2(MAX_BINS + 1);
  localparam int ADC_W   = 16;
  localparam int RUN_W   = 11;
  localparam int PEAK_W  = 10;
  localparam int LEN_W   = (CNT_W > RUN_W) ? CNT_W : RUN_W;
  localparam int BINX_W  = (BIN_W > PEAK_W) ? BIN_W : PEAK_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [ADC_W-1:0] THRESHOLD_RST = 16'sd150;
  localparam logic [RUN_W-1:0]        MIN_RUN_RST   = 11'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD      = 2'd0,
    CFG_MIN_RUN_LENGTH = 2'd1
  } cfg_idx_t;

endpackage
`default_nettype wire

@@ rtl/cfg_if.sv @@
`default_nettype none
interface cfg_if;
  import trpf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/in_if.sv @@
`default_nettype none
interface in_if;
  import trpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ADC_W-1:0] adc_sample;
  logic                    last_sample;

  modport source (output valid, output adc_sample, output last_sample, input ready);
  modport sink   (input valid, input adc_sample, input last_sample, output ready);
endinterface
`default_nettype wire

@@ rtl/out_if.sv @@
`default_nettype none
interface out_if;
  import trpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PEAK_W-1:0]       peak_bin;
  logic signed [ADC_W-1:0] peak_value;

  modport source (output valid, output peak_bin, output peak_value, input ready);
  modport sink   (input valid, input peak_bin, input peak_value, output ready);
endinterface
`default_nettype wire

@@ rtl/threshold_run_peak_finder.sv @@
// Threshold-run peak finder.
// in_chan carries one signed ADC sample per time bin of a strip, in bin order;
// last_sample marks the final bin. out_chan carries, per qualifying run, the
// bin and value of its maximum (the later bin on ties, zero peaks dropped).
// cfg_chan writes the threshold (index 0) and min_run_length (index 1); it is
// always ready and must only be used while no results are pending.
// Throughput: one sample per cycle unless a stalled result holds it off. The
// per-sample work (threshold compare, run-length subtract and compare, max
// update) sits between the run-state registers and the output register.
// Latency: a result appears on out_chan the cycle after the transfer of the
// sample that closes its run.
// Stall: out_chan is a single output register; in_chan.ready stays high while
// that register is empty or being drained, so a stalled receiver holds off the
// input only while a result is actually waiting.
// Reset (rst_n low, synchronous): run state and bin counter clear, the output
// register empties, registers return to threshold 150 and minimum length 3.
// Samples beyond MAX_BINS in a strip are taken and ignored until last_sample.
`default_nettype none
`include "threshold_run_peak_finder_assert.svh"
module threshold_run_peak_finder (
  input  wire    clk,
  input  wire    rst_n,
  cfg_if.sink    cfg_chan,
  in_if.sink     in_chan,
  out_if.source  out_chan
);
  import trpf_pkg::*;

  // configuration registers
  logic signed [ADC_W-1:0] thresh_r;
  logic [RUN_W-1:0]        min_run_r;

  // run state
  logic [CNT_W-1:0]        bin_cnt_r,   bin_cnt_nxt;
  logic                    in_run_r,    in_run_nxt;
  logic [BIN_W-1:0]        start_bin_r, start_bin_nxt;
  logic signed [ADC_W-1:0] best_val_r,  best_val_nxt;
  logic [BIN_W-1:0]        best_bin_r,  best_bin_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [PEAK_W-1:0]       out_bin_r,   out_bin_nxt;
  logic signed [ADC_W-1:0] out_value_r, out_value_nxt;

  logic                    in_fire;
  logic                    active;
  logic                    over;
  logic [BIN_W-1:0]        cur_bin;
  logic                    close_low;
  logic                    close_last;
  logic [LEN_W-1:0]        run_len;
  logic                    emit;
  logic [CNT_W-1:0]        cnt_step;
  logic                    run_step;
  logic [BIN_W-1:0]        start_step;
  logic signed [ADC_W-1:0] best_val_step;
  logic [BIN_W-1:0]        best_bin_step;
  logic [BINX_W-1:0]       best_bin_x;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign in_fire        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESHOLD_RST;
      min_run_r <= MIN_RUN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_idx_t'(cfg_chan.index))
        CFG_THRESHOLD:      thresh_r  <= $signed(cfg_chan.data[ADC_W-1:0]);
        CFG_MIN_RUN_LENGTH: min_run_r <= cfg_chan.data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample step: open/extend/close a run, then the strip-end flush.
  always_comb begin
    active  = bin_cnt_r < CNT_W'(MAX_BINS);
    over    = in_chan.adc_sample >= thresh_r;
    cur_bin = bin_cnt_r[BIN_W-1:0];

    cnt_step      = bin_cnt_r;
    run_step      = in_run_r;
    start_step    = start_bin_r;
    best_val_step = best_val_r;
    best_bin_step = best_bin_r;
    close_low     = 1'b0;

    if (active) begin
      cnt_step = bin_cnt_r + 1'b1;
      if (over) begin
        if (!in_run_r) begin
          run_step      = 1'b1;
          start_step    = cur_bin;
          best_val_step = in_chan.adc_sample;
          best_bin_step = cur_bin;
        end else if (in_chan.adc_sample >= best_val_r) begin
          best_val_step = in_chan.adc_sample;
          best_bin_step = cur_bin;
        end
      end else if (in_run_r) begin
        close_low = 1'b1;
        run_step  = 1'b0;
      end
    end

    // run still open at the strip end gets flushed
    close_last = in_chan.last_sample && run_step;

    // a low sample closes the run before the current bin
    if (close_low) begin
      run_len = LEN_W'(bin_cnt_r) - LEN_W'(start_bin_r);
    end else begin
      run_len = LEN_W'(cnt_step) - LEN_W'(start_step);
    end

    emit = (close_low || close_last) && (run_len >= LEN_W'(min_run_r)) &&
           (best_val_step != '0);

    best_bin_x = BINX_W'(best_bin_step);

    if (in_chan.last_sample) begin
      bin_cnt_nxt   = '0;
      in_run_nxt    = 1'b0;
      start_bin_nxt = '0;
      best_val_nxt  = '0;
      best_bin_nxt  = '0;
    end else begin
      bin_cnt_nxt   = cnt_step;
      in_run_nxt    = run_step;
      start_bin_nxt = start_step;
      best_val_nxt  = best_val_step;
      best_bin_nxt  = best_bin_step;
    end
  end

  // Output register: load on a sample transfer, drain on an output transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bin_nxt   = out_bin_r;
    out_value_nxt = out_value_r;
    if (in_fire) begin
      out_valid_nxt = emit;
      out_bin_nxt   = best_bin_x[PEAK_W-1:0];
      out_value_nxt = best_val_step;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r   <= '0;
      in_run_r    <= 1'b0;
      start_bin_r <= '0;
      best_val_r  <= '0;
      best_bin_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        bin_cnt_r   <= bin_cnt_nxt;
        in_run_r    <= in_run_nxt;
        start_bin_r <= start_bin_nxt;
        best_val_r  <= best_val_nxt;
        best_bin_r  <= best_bin_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bin_r   <= out_bin_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.peak_bin   = out_bin_r;
  assign out_chan.peak_value = out_value_r;

  `TRPF_ASSERT_NEXT(a_last_clears, clk, rst_n, in_fire && in_chan.last_sample, bin_cnt_r == '0 && !in_run_r)
  `TRPF_ASSERT_NOW(a_peak_nonzero, clk, rst_n, out_valid_r, out_value_r != '0)
  `TRPF_ASSERT_NOW(a_run_inside_strip, clk, rst_n, in_run_r, bin_cnt_r > CNT_W'(start_bin_r))
  `TRPF_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_r, in_chan.ready)

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import trpf_pkg::*;

  localparam int SETTLE_CYCLES = 4;  // block answers in the cycle after the closing transfer

  // Peak-per-run bookkeeping, mirrors the block's run state.
  class peak_scoreboard;
    typedef struct {
      logic [PEAK_W-1:0]       bin;
      logic signed [ADC_W-1:0] value;
    } peak_t;

    logic signed [ADC_W-1:0] threshold;
    logic [RUN_W-1:0]        min_len;
    logic [CNT_W-1:0]        bin_count;
    bit                      run_open;
    logic [PEAK_W-1:0]       run_start;
    logic signed [ADC_W-1:0] best_val;
    logic [PEAK_W-1:0]       best_bin;
    peak_t                   pending_peaks[$];
    int                      errors;

    function new();
      threshold = THRESHOLD_RST;
      min_len   = MIN_RUN_RST;
      errors    = 0;
      clear_strip();
    endfunction

    function void clear_strip();
      bin_count = '0;
      run_open  = 0;
      run_start = '0;
      best_val  = '0;
      best_bin  = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD:      threshold = data[ADC_W-1:0];
        CFG_MIN_RUN_LENGTH: min_len   = data[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit close_run(int length);
      peak_t p;
      run_open = 0;
      if (length < int'(min_len) || best_val == 0) return 0;
      p.bin   = best_bin;
      p.value = best_val;
      pending_peaks = {pending_peaks, p};
      return 1;
    endfunction

    // One accepted input transfer.
    function void note_sample(logic signed [ADC_W-1:0] s, logic last);
      bit emitted;
      emitted = 0;
      if (bin_count < MAX_BINS) begin
        if (s >= threshold) begin
          if (!run_open) begin
            run_open  = 1;
            run_start = bin_count[PEAK_W-1:0];
            best_val  = s;
            best_bin  = bin_count[PEAK_W-1:0];
          end else if (s >= best_val) begin
            best_val = s;
            best_bin = bin_count[PEAK_W-1:0];
          end
        end else if (run_open) begin
          emitted = close_run(int'(bin_count) - int'(run_start));
        end
        bin_count = bin_count + 1'b1;
      end
      if (last) begin
        if (run_open && !emitted) void'(close_run(int'(bin_count) - int'(run_start)));
        clear_strip();
      end
    endfunction

    // One accepted output transfer.
    function void check_peak(logic [PEAK_W-1:0] bin, logic signed [ADC_W-1:0] value);
      peak_t p;
      if (pending_peaks.size() == 0) begin
        errors++;
        $display("%0t: unexpected peak: expected none, actual bin %0d value %0d",
                 $time, bin, value);
        return;
      end
      p = pending_peaks.pop_front();
      if (bin !== p.bin) begin
        errors++;
        $display("%0t: peak_bin mismatch: expected %0d, actual %0d", $time, p.bin, bin);
      end
      if (value !== p.value) begin
        errors++;
        $display("%0t: peak_value mismatch: expected %0d, actual %0d",
                 $time, p.value, value);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cfg_if cfg_bus ();
  in_if  in_bus ();
  out_if out_bus ();

  threshold_run_peak_finder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  peak_scoreboard board = new();

  bit no_idle;         // final stretch: no gaps on either side
  bit long_hold_req;   // ask the receiver for one long hold-off
  int random_samples;
  logic signed [ADC_W-1:0] prev_over;  // reused to provoke ties

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Drive every input to a known value from time zero.
  initial begin
    rst_n              = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_THRESHOLD;
    cfg_bus.data       = '0;
    in_bus.valid       = 1'b0;
    in_bus.adc_sample  = '0;
    in_bus.last_sample = 1'b0;
    out_bus.ready      = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold counted here.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left     = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left    = $urandom_range(1, 13) - 1;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Result monitor: pre-edge values seen at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      board.check_peak(out_bus.peak_bin, out_bus.peak_value);
  end

  // Sample at or above the current threshold; biased to extremes, ties, zero peaks.
  function automatic logic signed [ADC_W-1:0] pick_over();
    int lo;
    int v;
    lo = int'(board.threshold);
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = 32767;
      2: v = (prev_over >= board.threshold) ? int'(prev_over) : lo;
      3: v = (lo <= 0) ? lo + int'($urandom_range(0, -lo)) : lo;
      default: v = lo + int'($urandom_range(0, 32767 - lo));
    endcase
    prev_over = ADC_W'(v);
    return ADC_W'(v);
  endfunction

  function automatic logic signed [ADC_W-1:0] pick_under();
    int hi;
    hi = int'(board.threshold) - 1;
    if (hi < -32768) return pick_over();  // nothing lies below the floor
    case ($urandom_range(0, 3))
      0: return ADC_W'(hi);
      1: return 16'sh8000;
      default: return ADC_W'(-32768 + int'($urandom_range(0, hi + 32768)));
    endcase
  endfunction

  // Input transfer; starts and ends at a falling edge, leaves valid high.
  task automatic send_sample(logic signed [ADC_W-1:0] s, logic last);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap          = $urandom_range(1, 13);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.adc_sample  = s;
    in_bus.last_sample = last;
    do @(posedge clk); while (!in_bus.ready);
    board.note_sample(s, last);
    @(negedge clk);
  endtask

  // Sender pause until every expected peak is out, then let the block settle.
  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (board.pending_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_config(int thr, int min_run);
    wait_drained();
    write_reg(CFG_THRESHOLD, thr[CFG_DATA_W-1:0]);
    write_reg(CFG_MIN_RUN_LENGTH, min_run[CFG_DATA_W-1:0]);
  endtask

  // Strip of alternating runs and gaps with random content, or plain noise.
  task automatic send_strip(int len, bit noise);
    int run_left;
    int gap_left;
    logic signed [ADC_W-1:0] s;
    run_left = 0;
    gap_left = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        s = ADC_W'($urandom);
      end else begin
        if (run_left == 0 && gap_left == 0) run_left = $urandom_range(1, 8);
        if (run_left > 0) begin
          s = pick_over();
          run_left--;
          if (run_left == 0) gap_left = $urandom_range(1, 4);
        end else begin
          s = pick_under();
          gap_left--;
        end
      end
      send_sample(s, i == len - 1);
    end
  endtask

  task automatic random_config();
    int thr;
    int min_run;
    case ($urandom_range(0, 6))
      0: thr = -32768;
      1: thr = 32767;
      2: thr = 0;
      3: thr = 150;
      4: thr = -int'($urandom_range(0, 200));
      5: thr = int'($urandom_range(100, 2000));
      default: thr = int'($signed(16'($urandom)));
    endcase
    case ($urandom_range(0, 5))
      0: min_run = 0;
      1: min_run = 1;
      2: min_run = 2;
      3: min_run = 3;
      default: min_run = $urandom_range(0, 8);
    endcase
    set_config(thr, min_run);
  endtask

  task automatic random_phase(int strips);
    int len;
    for (int k = 0; k < strips; k++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      send_strip(len, $urandom_range(0, 6) == 0);
      random_samples += len;
    end
  endtask

  initial begin : stimulus
    no_idle        = 0;
    long_hold_req  = 0;
    random_samples = 0;
    prev_over      = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed, reset settings (threshold 150, min run 3).
    // Run closed by a low sample on the last bin; tie on full scale.
    send_sample(16'sd149, 1'b0);
    send_sample(16'sd150, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // Run reaching the end of the strip, exactly min length, at threshold.
    send_sample(16'sd150, 1'b0);
    send_sample(16'sd150, 1'b0);
    send_sample(16'sd150, 1'b1);
    // Runs too short, two of them ended by the strip end.
    send_sample(16'sd500, 1'b0);
    send_sample(16'sd500, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd900, 1'b0);
    send_sample(16'sd900, 1'b1);
    send_sample(16'sh7fff, 1'b1);

    // Zero peaks dropped; min run of zero lets any run through.
    set_config(0, 0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd0, 1'b1);

    // Random phases, each with its own settings.
    while (random_samples < 200) begin
      random_config();
      random_phase($urandom_range(3, 8));
    end

    // Receiver holds off while samples keep coming; one result per two bins.
    set_config(150, 1);
    long_hold_req = 1;
    for (int i = 0; i < 120; i++)
      send_sample((i % 2 == 0) ? pick_over() : pick_under(), i % 20 == 19);
    wait_drained();

    // Last stretch without idling on either side.
    set_config(-100, 1);
    no_idle = 1;
    random_phase(5);
    random_config();
    random_phase(4);

    wait_drained();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/trpf_pkg.sv
rtl/cfg_if.sv
rtl/in_if.sv
rtl/out_if.sv
rtl/threshold_run_peak_finder.sv
bench/testbench.sv
